[hw/rtl/srfd_pkg.sv]
// Shared types and constants for the sprite row fetch and decode block.
// Holds the beat structs of both channels and the stage-to-stage structs.
// No dependencies.
`timescale 1ns / 1ps

package srfd_pkg;

	localparam int GFX_AW    = 12;
	localparam int GFX_DEPTH = 1 << GFX_AW;

	// Configuration register indexes.
	localparam logic CFG_COLOR_STACK = 1'b0;
	localparam logic CFG_HDELAY      = 1'b1;

	localparam logic ACTION_WRITE = 1'b0;
	localparam logic ACTION_EVAL  = 1'b1;

	localparam logic [11:0] CARD_MASK      = 12'h0ff8;
	localparam logic [11:0] YRES_CARD_MASK = 12'hff0;
	localparam logic [11:0] FGBG_CARD_MASK = 12'h9f8;
	localparam logic [7:0]  X_LIMIT        = 8'd167;
	localparam logic [6:0]  Y_LIMIT        = 7'd104;
	localparam logic [6:0]  LINE_LIMIT     = 7'd104;

	typedef struct packed {
		logic        action;
		logic [11:0] gfx_address;
		logic [7:0]  gfx_data;
		logic [13:0] pos_word;
		logic [13:0] vert_word;
		logic [13:0] attr_word;
		logic [2:0]  sprite_index;
		logic [6:0]  line_number;
	} sprite_item_t;

	typedef struct packed {
		logic       on_line;
		logic [8:0] start_x;
		logic [7:0] upper_bits;
		logic [7:0] lower_bits;
		logic       wide;
		logic [3:0] color_index;
		logic       shown;
		logic       interacts;
		logic       behind_cards;
		logic [7:0] collision_mask;
	} result_item_t;

	// Sprite attributes that ride along with the row fetch.
	typedef struct packed {
		logic       draw;
		logic       flip_x;
		logic [8:0] start_x;
		logic       wide;
		logic [3:0] color_index;
		logic       shown;
		logic       interacts;
		logic       behind_cards;
		logic [2:0] sprite_index;
	} sprite_meta_t;

	typedef struct packed {
		logic              is_write;
		logic [GFX_AW-1:0] gfx_address;
		logic [7:0]        gfx_data;
		logic [11:0]       card;
		logic [3:0]        row;
		logic              flip_y;
		logic              size0;
		sprite_meta_t      meta;
	} decode_t;

	typedef struct packed {
		sprite_meta_t meta;
		logic [7:0]   upper;
		logic [7:0]   lower;
	} fetch_t;

endpackage

[hw/rtl/srfd_decode.sv]
// First stage: disable rules, card limit, height check and row selection.
// Depends on srfd_pkg.
`timescale 1ns / 1ps

module srfd_decode (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_in,
	input  srfd_pkg::sprite_item_t item,
	input  logic                   color_stack_mode,
	input  logic [2:0]             horizontal_delay,
	input  logic                   ready_next,
	output logic                   ready,
	output logic                   valid_s1,
	output srfd_pkg::decode_t      dec_s1
);

	logic [7:0]  pos_x;
	logic [6:0]  pos_y;
	logic        yres;
	logic [1:0]  size;
	logic [6:0]  height;
	logic [6:0]  offset;
	logic        enable;
	logic        covers;
	logic [3:0]  row_raw;
	logic [11:0] card;
	logic [8:0]  x_sum;
	srfd_pkg::decode_t dec;

	assign ready = !valid_s1 || ready_next;

	always_comb begin
		pos_x  = item.pos_word[7:0];
		pos_y  = item.vert_word[6:0];
		yres   = item.vert_word[7];
		size   = item.vert_word[9:8];
		height = 7'd4 << ({1'b0, size} + {2'b00, yres});
		offset = item.line_number - pos_y;
		enable = (item.line_number <= srfd_pkg::LINE_LIMIT) && (pos_x != 8'd0)
			&& (pos_x < srfd_pkg::X_LIMIT) && (item.pos_word[9:8] != 2'b00)
			&& (pos_y < srfd_pkg::Y_LIMIT);
		covers = (item.line_number >= pos_y) && (offset < height);

		// Size zero shows each graphics row pair as one line step of two rows.
		if (size == 2'd0) begin
			row_raw = {offset[2:0], 1'b0};
		end else begin
			row_raw = 4'(offset >> (size - 2'd1));
		end

		card = item.attr_word[11:0] & srfd_pkg::CARD_MASK;
		if (yres) begin
			card = card & srfd_pkg::YRES_CARD_MASK;
		end
		if (!color_stack_mode || item.attr_word[11]) begin
			card = card & srfd_pkg::FGBG_CARD_MASK;
		end

		x_sum = 9'(pos_x) + 9'(horizontal_delay);

		dec.is_write    = (item.action == srfd_pkg::ACTION_WRITE);
		dec.gfx_address = item.gfx_address;
		dec.gfx_data    = item.gfx_data;
		dec.card        = card;
		dec.flip_y      = item.vert_word[11];
		dec.row         = item.vert_word[11] ? ({yres, 3'b111} - row_raw) : row_raw;
		dec.size0       = (size == 2'd0);
		dec.meta.draw   = (item.action == srfd_pkg::ACTION_EVAL) && enable && covers;
		dec.meta.flip_x       = item.vert_word[10];
		dec.meta.start_x      = {x_sum[7:0], 1'b0};
		dec.meta.wide         = item.pos_word[10];
		dec.meta.color_index  = {item.attr_word[12], item.attr_word[2:0]};
		dec.meta.shown        = item.pos_word[9];
		dec.meta.interacts    = item.pos_word[8];
		dec.meta.behind_cards = item.attr_word[13];
		dec.meta.sprite_index = item.sprite_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid_in) begin
			dec_s1 <= dec;
		end
	end

endmodule

[hw/rtl/srfd_fetch.sv]
// Second stage: graphics store with one write port and two read ports.
// Store writes and row reads happen in item order. Depends on srfd_pkg.
`timescale 1ns / 1ps

module srfd_fetch (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_in,
	input  srfd_pkg::decode_t dec,
	input  logic              ready_next,
	output logic              ready,
	output logic              valid_s2,
	output srfd_pkg::fetch_t  fet_s2
);

	logic [7:0] gfx_mem [srfd_pkg::GFX_DEPTH];
	logic [srfd_pkg::GFX_AW-1:0] addr_upper;
	logic [srfd_pkg::GFX_AW-1:0] addr_lower;
	logic [srfd_pkg::GFX_AW-1:0] addr_step;
	logic [7:0] upper_s2;
	logic [7:0] lower_s2;
	srfd_pkg::sprite_meta_t meta_s2;
	logic load;

	assign ready = !valid_s2 || ready_next;
	assign load  = ready && valid_in;

	// Size zero reads its lower row from the neighboring address.
	always_comb begin
		addr_step  = {{(srfd_pkg::GFX_AW-1){1'b0}}, dec.size0};
		addr_upper = dec.card + {8'b0, dec.row};
		addr_lower = dec.flip_y ? (addr_upper - addr_step) : (addr_upper + addr_step);
	end

	always_ff @(posedge clk) begin
		if (load && dec.is_write) begin
			gfx_mem[dec.gfx_address] <= dec.gfx_data;
		end
		if (load && !dec.is_write) begin
			upper_s2 <= gfx_mem[addr_upper];
			lower_s2 <= gfx_mem[addr_lower];
		end
		if (load) begin
			meta_s2 <= dec.meta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= valid_in;
		end
	end

	assign fet_s2.meta  = meta_s2;
	assign fet_s2.upper = upper_s2;
	assign fet_s2.lower = lower_s2;

endmodule

[hw/rtl/srfd_format.sv]
// Third stage: horizontal flip, collision bit and output register.
// Depends on srfd_pkg.
`timescale 1ns / 1ps

module srfd_format (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_in,
	input  srfd_pkg::fetch_t         fet,
	input  logic                     ready_next,
	output logic                     ready,
	output logic                     valid_s3,
	output srfd_pkg::result_item_t   res_s3
);

	srfd_pkg::result_item_t res;

	function automatic logic [7:0] flip_byte(input logic [7:0] v);
		logic [7:0] r;
		for (int b = 0; b < 8; b++) begin
			r[b] = v[7-b];
		end
		return r;
	endfunction

	assign ready = !valid_s3 || ready_next;

	always_comb begin
		res = '0;
		// Writes and undrawn sprites give an all-zero beat.
		if (fet.meta.draw) begin
			res.on_line        = 1'b1;
			res.start_x        = fet.meta.start_x;
			res.upper_bits     = fet.meta.flip_x ? flip_byte(fet.upper) : fet.upper;
			res.lower_bits     = fet.meta.flip_x ? flip_byte(fet.lower) : fet.lower;
			res.wide           = fet.meta.wide;
			res.color_index    = fet.meta.color_index;
			res.shown          = fet.meta.shown;
			res.interacts      = fet.meta.interacts;
			res.behind_cards   = fet.meta.behind_cards;
			res.collision_mask = 8'd1 << fet.meta.sprite_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready) begin
			valid_s3 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid_in) begin
			res_s3 <= res;
		end
	end

endmodule

[hw/rtl/sprite_row_fetch_decode.sv]
// Sprite row fetch and decode. Takes one beat per cycle while sprite_stall is low, graphics store
// writes and sprite evaluations alike, and returns one result beat for each, in order. Decode, the
// dual-read graphics store stage and the output stage each hold one item, and bubbles close up so
// input is taken while a result waits. The 4096-byte store is not cleared at reset; entries must
// be written before sprites use them.
// Depends on srfd_pkg, srfd_decode, srfd_fetch and srfd_format.
`timescale 1ns / 1ps

module sprite_row_fetch_decode (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic                     cfg_index,
	input  logic [2:0]               cfg_data,
	input  logic                     sprite_valid,
	output logic                     sprite_stall,
	input  srfd_pkg::sprite_item_t   sprite_item,
	output logic                     result_valid,
	input  logic                     result_stall,
	output srfd_pkg::result_item_t   result_item
);

	logic       color_stack_mode_q;
	logic [2:0] horizontal_delay_q;

	logic              stage1_ready;
	logic              stage2_ready;
	logic              stage3_ready;
	logic              valid_s1;
	logic              valid_s2;
	srfd_pkg::decode_t dec_s1;
	srfd_pkg::fetch_t  fet_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_stack_mode_q <= 1'b1;
			horizontal_delay_q <= 3'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				srfd_pkg::CFG_COLOR_STACK: color_stack_mode_q <= cfg_data[0];
				srfd_pkg::CFG_HDELAY:      horizontal_delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	srfd_decode u_decode (
		.clk              (clk),
		.arst_n           (arst_n),
		.valid_in         (sprite_valid),
		.item             (sprite_item),
		.color_stack_mode (color_stack_mode_q),
		.horizontal_delay (horizontal_delay_q),
		.ready_next       (stage2_ready),
		.ready            (stage1_ready),
		.valid_s1         (valid_s1),
		.dec_s1           (dec_s1)
	);

	srfd_fetch u_fetch (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_in   (valid_s1),
		.dec        (dec_s1),
		.ready_next (stage3_ready),
		.ready      (stage2_ready),
		.valid_s2   (valid_s2),
		.fet_s2     (fet_s2)
	);

	srfd_format u_format (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_in   (valid_s2),
		.fet        (fet_s2),
		.ready_next (!result_stall),
		.ready      (stage3_ready),
		.valid_s3   (result_valid),
		.res_s3     (result_item)
	);

	assign sprite_stall = !stage1_ready;

	// An empty first stage never pushes back on the input.
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !sprite_stall)
		else $error("input stalled with an empty decode stage");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		sprite_valid && !sprite_stall |=> valid_s1)
		else $error("accepted beat did not reach the decode stage");

	// A fetch stage blocked by the output stage must keep its row bytes.
	a_fetch_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !stage3_ready |=> valid_s2 && $stable(fet_s2))
		else $error("fetch stage changed while blocked");

	a_mask_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.on_line |-> $onehot(result_item.collision_mask))
		else $error("drawn sprite without a single collision bit");

endmodule
